>>> design/cre_pkg.sv
package cre_pkg;

  // Width of the internal Horner values; holds the largest intermediate term.
  localparam int VW = 38;

  // Largest usable slot count, fixed by the 4-bit slot field.
  localparam int SLOT_LIMIT = 16;

  // Request action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // Register index of the loop size, as seen in paddr[2].
  localparam logic REG_COUNT = 1'b0;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [VW-1:0] wide_t;

  // Half of v rounded half up, saturated to signed 32 bits.
  function automatic coord_t sat_half(input wide_t v);
    wide_t r;
    r = (v + wide_t'(1)) >>> 1;
    if (r[VW-1:31] == {(VW-31){r[31]}}) begin
      return r[31:0];
    end
    return r[VW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

>>> design/catmull_rom_curve_eval_top.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  action, point_index, coord_x/y/z, global_t
// out       output     out_valid/out_stall  pos_x/y/z, slope_x/y/z
// cfg       input      APB (psel, penable)  loop_size at address 0
// One request enters per cycle unless a stalled output holds the pipeline.
// An evaluate passes the input register, the registered table read and a
// seven-stage Horner datapath that multiplies in every other stage.
// Writes complete in the input stage and produce no result.
// Reset clears valid bits and sets loop_size to 4; the point table is not cleared.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module catmull_rom_curve_eval_top #(
  parameter int MAX_POINTS  = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [3:0]  point_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [15:0] global_t,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] slope_x,
  output logic signed [31:0] slope_y,
  output logic signed [31:0] slope_z
);

  localparam int NMAX = (MAX_POINTS < cre_pkg::SLOT_LIMIT) ? MAX_POINTS : cre_pkg::SLOT_LIMIT;
  localparam int AW   = $clog2(NMAX);
  localparam int DEPTH = 7;

  typedef logic [95:0] point_t;

  logic [4:0] loop_size;
  logic       en;
  logic       s0_valid, s0_action;
  logic [3:0] s0_index;
  point_t     s0_point;
  logic [15:0] s0_t;
  logic       s1_valid;
  logic [T_FRAC_BITS-1:0] s1_u, s0_u;
  logic [DEPTH-1:0] vpipe;
  logic [4:0] n_eff, seg, ix0, ix1, ix2, ix3, seg_inc, ix2_inc;
  logic [20:0] scaled;
  logic [39:0] frac_ext;
  logic [AW-1:0] raddr [4];
  point_t     rdata [4];
  logic       wr_en;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cre_pkg::REG_COUNT) ? {27'b0, loop_size} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_size <= 5'd4;
    end else if (psel && penable && pwrite && pready && paddr[2] == cre_pkg::REG_COUNT) begin
      loop_size <= pwdata[4:0];
    end
  end

  // The whole pipeline advances unless the output holds a stalled result.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_action <= action;
      s0_index  <= point_index;
      s0_point  <= {coord_z, coord_y, coord_x};
      s0_t      <= global_t;
    end
  end

  // Effective count, segment split and wrapped neighbor indexes.
  always_comb begin
    if (loop_size == 5'd0) begin
      n_eff = 5'd1;
    end else if (loop_size > 5'(NMAX)) begin
      n_eff = 5'(NMAX);
    end else begin
      n_eff = loop_size;
    end
  end

  assign scaled   = 21'(s0_t) * 21'(n_eff);
  assign seg      = scaled[20:16];
  assign frac_ext = {scaled[15:0], 24'b0};
  assign s0_u     = frac_ext[39 -: T_FRAC_BITS];
  assign seg_inc  = seg + 5'd1;
  assign ix0      = (seg == 5'd0) ? n_eff - 5'd1 : seg - 5'd1;
  assign ix1      = seg;
  assign ix2      = (seg_inc == n_eff) ? 5'd0 : seg_inc;
  assign ix2_inc  = ix2 + 5'd1;
  assign ix3      = (ix2_inc == n_eff) ? 5'd0 : ix2_inc;

  assign raddr[0] = ix0[AW-1:0];
  assign raddr[1] = ix1[AW-1:0];
  assign raddr[2] = ix2[AW-1:0];
  assign raddr[3] = ix3[AW-1:0];

  assign wr_en = en && s0_valid && s0_action == cre_pkg::ACT_WRITE
                 && 9'(s0_index) < 9'(NMAX);

  // Four copies of the point table, one per neighbor, each with one read port.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    point_t bank [NMAX];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        bank[s0_index[AW-1:0]] <= s0_point;
      end
      if (en) begin
        rdata[k] <= bank[raddr[k]];
      end
    end
  end

  // Read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      vpipe    <= '0;
    end else if (en) begin
      s1_valid <= s0_valid && s0_action == cre_pkg::ACT_EVAL;
      vpipe    <= {vpipe[DEPTH-2:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u <= s0_u;
    end
  end

  assign out_valid = vpipe[DEPTH-1];

  // Per-axis Horner datapaths.
  cre_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_x (
    .clk(clk), .en(en),
    .p0(rdata[0][31:0]), .p1(rdata[1][31:0]), .p2(rdata[2][31:0]), .p3(rdata[3][31:0]),
    .u(s1_u), .pos(pos_x), .slope(slope_x)
  );

  cre_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_y (
    .clk(clk), .en(en),
    .p0(rdata[0][63:32]), .p1(rdata[1][63:32]), .p2(rdata[2][63:32]),
    .p3(rdata[3][63:32]),
    .u(s1_u), .pos(pos_y), .slope(slope_y)
  );

  cre_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_z (
    .clk(clk), .en(en),
    .p0(rdata[0][95:64]), .p1(rdata[1][95:64]), .p2(rdata[2][95:64]),
    .p3(rdata[3][95:64]),
    .u(s1_u), .pos(pos_z), .slope(slope_z)
  );

  // An accepted request lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s0_valid)
    else $error("accepted request did not reach the input stage");

  // Neighbor indexes ix0, ix1 (seg) and ix3 stay inside the active loop.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && s0_action == cre_pkg::ACT_EVAL)
      |-> (ix0 < n_eff && ix3 < n_eff && seg < n_eff))
    else $error("neighbor index outside point count");

  // A stalled result stays on the output.
  a_stall_chain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

>>> design/cre_axis.sv
module cre_axis #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  cre_pkg::coord_t        p0,
  input  cre_pkg::coord_t        p1,
  input  cre_pkg::coord_t        p2,
  input  cre_pkg::coord_t        p3,
  input  logic [T_FRAC_BITS-1:0] u,
  output cre_pkg::coord_t        pos,
  output cre_pkg::coord_t        slope
);

  localparam int VW = cre_pkg::VW;
  localparam int PW = VW + T_FRAC_BITS + 1;

  typedef logic signed [PW-1:0] prod_t;

  // Product rounded half up and scaled back by the fraction width.
  function automatic cre_pkg::wide_t rnd(input prod_t p);
    prod_t s;
    s = (p + $signed({{(PW-T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}}))
        >>> T_FRAC_BITS;
    return s[VW-1:0];
  endfunction

  cre_pkg::wide_t e0, e1, e2, e3;
  cre_pkg::wide_t a_c3, a_c3x3, a_c2, a_c1, a_c0;
  logic [T_FRAC_BITS-1:0] a_u, b_u, c_u, d_u, d_u_hold;
  prod_t b_ph, b_pg, d_ph, d_pg, f_ph;
  cre_pkg::wide_t b_c2, b_c1, b_c0, c_h, c_g, c_c1, c_c0;
  cre_pkg::wide_t d_c1, d_c0, e_h, e_g, e_c0, f_g, f_c0, g_pos;
  prod_t us;

  assign e0 = cre_pkg::wide_t'(p0);
  assign e1 = cre_pkg::wide_t'(p1);
  assign e2 = cre_pkg::wide_t'(p2);
  assign e3 = cre_pkg::wide_t'(p3);

  // Stage A: doubled polynomial coefficients.
  always_ff @(posedge clk) begin
    if (en) begin
      a_c3   <= -e0 + 3 * e1 - 3 * e2 + e3;
      a_c3x3 <= -3 * e0 + 9 * e1 - 9 * e2 + 3 * e3;
      a_c2   <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
      a_c1   <= e2 - e0;
      a_c0   <= 2 * e1;
      a_u    <= u;
    end
  end

  // Stage B: first products of both Horner chains.
  always_ff @(posedge clk) begin
    if (en) begin
      b_ph <= prod_t'(a_c3) * $signed({{(PW-T_FRAC_BITS){1'b0}}, a_u});
      b_pg <= prod_t'(a_c3x3) * $signed({{(PW-T_FRAC_BITS){1'b0}}, a_u});
      b_c2 <= a_c2;
      b_c1 <= a_c1;
      b_c0 <= a_c0;
      b_u  <= a_u;
    end
  end

  // Stage C: add the second coefficient.
  always_ff @(posedge clk) begin
    if (en) begin
      c_h  <= b_c2 + rnd(b_ph);
      c_g  <= (b_c2 <<< 1) + rnd(b_pg);
      c_c1 <= b_c1;
      c_c0 <= b_c0;
      c_u  <= b_u;
    end
  end

  assign us = $signed({{(PW-T_FRAC_BITS){1'b0}}, c_u});

  // Stage D: second products.
  always_ff @(posedge clk) begin
    if (en) begin
      d_ph <= prod_t'(c_h) * us;
      d_pg <= prod_t'(c_g) * us;
      d_c1 <= c_c1;
      d_c0 <= c_c0;
      d_u  <= c_u;
    end
  end

  // Stage E: add the linear coefficient; the slope chain ends here.
  always_ff @(posedge clk) begin
    if (en) begin
      e_h  <= d_c1 + rnd(d_ph);
      e_g  <= d_c1 + rnd(d_pg);
      e_c0 <= d_c0;
    end
  end

  // Stage F: last product of the position chain.
  always_ff @(posedge clk) begin
    if (en) begin
      f_ph <= prod_t'(e_h) * $signed({{(PW-T_FRAC_BITS){1'b0}}, d_u_hold});
      f_g  <= e_g;
      f_c0 <= e_c0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_u_hold <= d_u;
    end
  end

  assign g_pos = f_c0 + rnd(f_ph);

  // Stage G: halve, round and saturate into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      pos   <= cre_pkg::sat_half(g_pos);
      slope <= cre_pkg::sat_half(f_g);
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef cre_pkg::coord_t coord_t;

  localparam logic [2:0] CFG_COUNT_ADDR = {cre_pkg::REG_COUNT, 2'b00};
  localparam logic [2:0] CFG_SPARE_ADDR = 3'd4;
  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic act;
    logic [3:0] slot;
    coord_t cx, cy, cz;
    logic [15:0] gt;
  } request_t;

  typedef struct {
    coord_t px, py, pz, sx, sy, sz;
  } curve_pt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [3:0] point_index = '0;
  coord_t coord_x = '0, coord_y = '0, coord_z = '0;
  logic [15:0] global_t = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t pos_x, pos_y, pos_z, slope_x, slope_y, slope_z;

  request_t pend_q[$];
  curve_pt_t curve_q[$];
  coord_t tab_x[16], tab_y[16], tab_z[16];
  logic [4:0] count_reg = 5'd4;
  int err_cnt = 0;
  int n_store = 0, n_eval = 0, n_checked = 0, n_cfg = 0;
  int quiet = 0;
  logic taken = 1'b0;
  logic calm = 1'b0;
  int gap_left = 0, stall_left = 0;

  catmull_rom_curve_eval_top i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .point_index(point_index), .coord_x(coord_x), .coord_y(coord_y),
    .coord_z(coord_z), .global_t(global_t),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .slope_x(slope_x), .slope_y(slope_y), .slope_z(slope_z)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Rounded product of a Horner term with the local t.
  function automatic longint round_mul(input longint h, input longint u);
    return (h * u + 64'sd32768) >>> 16;
  endfunction

  // Half of v rounded half up, clamped to signed 32 bits.
  function automatic coord_t halve_clamp(input longint v);
    longint r;
    r = (v + 1) >>> 1;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return coord_t'(r);
  endfunction

  // Position and slope along one axis for the four neighbouring points.
  function automatic void spline_axis(input coord_t q0, input coord_t q1, input coord_t q2,
                                      input coord_t q3, input longint u,
                                      output coord_t pos, output coord_t slope);
    longint p0, p1, p2, p3, c3, c2, c1, c0, h, g;
    p0 = q0; p1 = q1; p2 = q2; p3 = q3;
    c3 = -p0 + 3 * p1 - 3 * p2 + p3;
    c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c1 = p2 - p0;
    c0 = 2 * p1;
    h = c2 + round_mul(c3, u);
    h = c1 + round_mul(h, u);
    h = c0 + round_mul(h, u);
    g = 2 * c2 + round_mul(3 * c3, u);
    g = c1 + round_mul(g, u);
    pos = halve_clamp(h);
    slope = halve_clamp(g);
  endfunction

  // Expected curve point for a parameter under the current point count.
  function automatic curve_pt_t curve_at(input logic [15:0] gt);
    curve_pt_t r;
    int n, seg, i0, i1, i2, i3;
    logic [31:0] scaled;
    longint u;
    n = count_reg;
    if (n > 16) n = 16;
    if (n == 0) n = 1;
    scaled = gt * n;
    seg = scaled[31:16];
    u = scaled[15:0];
    i0 = (seg + n - 1) % n;
    i1 = (i0 + 1) % n;
    i2 = (i1 + 1) % n;
    i3 = (i2 + 1) % n;
    spline_axis(tab_x[i0], tab_x[i1], tab_x[i2], tab_x[i3], u, r.px, r.sx);
    spline_axis(tab_y[i0], tab_y[i1], tab_y[i2], tab_y[i3], u, r.py, r.sy);
    spline_axis(tab_z[i0], tab_z[i1], tab_z[i2], tab_z[i3], u, r.pz, r.sz);
    return r;
  endfunction

  task automatic report(input string what, input coord_t got, input coord_t want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Request side: accept, mirror table writes, queue expected points.
  // Result side: compare with the oldest expectation. Also the watchdog.
  always @(posedge clk) begin
    curve_pt_t e;
    if (!rst) begin
      taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (curve_q.size() == 0) begin
          $display("%0t result with no evaluate request pending", $realtime);
          err_cnt++;
        end else begin
          e = curve_q.pop_front();
          n_checked++;
          if (pos_x !== e.px) report("pos_x", pos_x, e.px);
          if (pos_y !== e.py) report("pos_y", pos_y, e.py);
          if (pos_z !== e.pz) report("pos_z", pos_z, e.pz);
          if (slope_x !== e.sx) report("slope_x", slope_x, e.sx);
          if (slope_y !== e.sy) report("slope_y", slope_y, e.sy);
          if (slope_z !== e.sz) report("slope_z", slope_z, e.sz);
        end
      end
      if (in_valid && !in_stall) begin
        if (action == cre_pkg::ACT_WRITE) begin
          tab_x[point_index] = coord_x;
          tab_y[point_index] = coord_y;
          tab_z[point_index] = coord_z;
        end else begin
          curve_q.push_back(curve_at(global_t));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Request driver with random gaps.
  always @(negedge clk) begin
    request_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (!calm && pend_q.size() > 0 && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        it = pend_q.pop_front();
        action <= it.act;
        point_index <= it.slot;
        coord_x <= it.cx;
        coord_y <= it.cy;
        coord_z <= it.cz;
        global_t <= it.gt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall in random bursts.
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == CFG_COUNT_ADDR) count_reg = value[4:0];
    n_cfg++;
  endtask

  // Wait until every request is sent and every point has come back.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (curve_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 4))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return coord_t'($urandom_range(0, 2 ** 21)) - 32'sd1048576;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic add_store(input logic [3:0] slot, input coord_t x, input coord_t y,
                           input coord_t z);
    request_t it;
    it.act = cre_pkg::ACT_WRITE; it.slot = slot; it.cx = x; it.cy = y; it.cz = z;
    it.gt = 16'($urandom);
    pend_q.push_back(it);
    n_store++;
  endtask

  task automatic add_eval(input logic [15:0] gt);
    request_t it;
    it.act = cre_pkg::ACT_EVAL; it.slot = 4'($urandom);
    it.cx = coord_t'($urandom); it.cy = coord_t'($urandom); it.cz = coord_t'($urandom);
    it.gt = gt;
    pend_q.push_back(it);
    n_eval++;
  endtask

  function automatic logic [15:0] pick_t();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [31:0] counts[10];
    counts = '{32'd1, 32'd16, 32'd0, 32'd17, 32'hffff_ffff, 32'd2, 32'd3, 32'd7,
               32'd12, 32'd5};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill every slot first, with extreme points in the reset count's window.
    add_store(4'd0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0);
    add_store(4'd1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd65536);
    add_store(4'd2, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd65536);
    add_store(4'd3, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd1);
    for (int s = 4; s < 16; s++) add_store(4'(s), pick_coord(), pick_coord(), pick_coord());
    add_eval(16'h0000);
    add_eval(16'hffff);
    add_eval(16'h8000);
    add_eval(16'h4000);
    add_eval(16'h0001);
    add_eval(16'h3fff);

    // The sender holds off until every point is back before each setting change.
    drain();
    cfg_write(CFG_SPARE_ADDR, 32'd9);
    for (int ph = 0; ph < 10; ph++) begin
      cfg_write(CFG_COUNT_ADDR, ph == 9 ? 32'($urandom_range(1, 16)) : counts[ph]);
      if (ph == 9) calm = 1'b1;
      for (int k = 0; k < 53; k++) begin
        if ($urandom_range(0, 3) == 0)
          add_store(4'($urandom), pick_coord(), pick_coord(), pick_coord());
        else
          add_eval(pick_t());
      end
      drain();
    end

    $display("covered %0d point writes, %0d evaluates (%0d checked), %0d register writes",
             n_store, n_eval, n_checked, n_cfg);
    $display("point counts swept from 1 to 16 plus zero and out-of-range values");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
